// ===== rtl/core/vspr_pkg.sv =====
// Shared types and constants for the tagged-word data stack.
package vspr_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int IDX_IN_W        = 6;
	localparam int TAG_W           = 2;
	localparam int BITS_W          = 64;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PICK = 2'd2,
		CMD_ROLL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Whole-stack move ordered by the control path
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2,
		OP_ROLL = 2'd3
	} stk_op_t;

	// Per-cell source select
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_PREV = 2'd1,
		CELL_NEXT = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [BITS_W-1:0] bits;
	} word_t;

	typedef struct packed {
		stk_op_t             op;
		logic [IDX_IN_W-1:0] idx;
	} chain_ctrl_t;

endpackage

// ===== rtl/core/vspr_cell.sv =====
// One stack cell: holds a single tagged word and loads from either neighbour.
module vspr_cell (
	input  logic           clk,
	input  vspr_pkg::cell_op_t op,
	input  logic           hit,
	input  vspr_pkg::word_t prev_word,
	input  vspr_pkg::word_t next_word,
	output vspr_pkg::word_t word,
	output vspr_pkg::word_t sel_word
);
	import vspr_pkg::*;

	word_t word_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_PREV: word_q <= prev_word;
			CELL_NEXT: word_q <= next_word;
			default:   word_q <= word_q;
		endcase
	end

	assign word     = word_q;
	// drive the shared read bus only when addressed
	assign sel_word = hit ? word_q : '0;

endmodule

// ===== rtl/core/vspr_chain.sv =====
// Row of stack cells, top of stack in cell 0, with the indexed read bus.
module vspr_chain #(
	parameter int STACK_DEPTH = vspr_pkg::DEF_STACK_DEPTH
) (
	input  logic                 clk,
	input  vspr_pkg::chain_ctrl_t ctrl,
	input  vspr_pkg::word_t      push_word,
	output vspr_pkg::word_t      top_word,
	output vspr_pkg::word_t      sel_word
);
	import vspr_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

	word_t    cell_word [STACK_DEPTH];
	word_t    cell_sel  [STACK_DEPTH];
	logic     cell_hit  [STACK_DEPTH];
	word_t    head_word;

	// new top: the pushed word, or the word lifted out by a roll
	assign head_word = (ctrl.op == OP_PUSH) ? push_word : sel_word;
	assign top_word  = cell_word[0];

	always_comb begin
		sel_word = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			sel_word = sel_word | cell_sel[i];
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		word_t    prev_w;
		word_t    next_w;
		logic     upto;
		cell_op_t op_sel;

		assign cell_hit[i] = (CMP_W'(i) == CMP_W'(ctrl.idx));
		assign upto        = (CMP_W'(i) <= CMP_W'(ctrl.idx));

		always_comb begin
			case (ctrl.op)
				OP_PUSH: op_sel = CELL_PREV;
				OP_POP:  op_sel = CELL_NEXT;
				OP_ROLL: op_sel = upto ? CELL_PREV : CELL_HOLD;
				default: op_sel = CELL_HOLD;
			endcase
		end

		if (i == 0) begin : g_head
			assign prev_w = head_word;
		end else begin : g_body
			assign prev_w = cell_word[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_tail
			assign next_w = '0;
		end else begin : g_inner
			assign next_w = cell_word[i+1];
		end

		vspr_cell u_cell (
			.clk       (clk),
			.op        (op_sel),
			.hit       (cell_hit[i]),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (cell_word[i]),
			.sel_word  (cell_sel[i])
		);
	end

endmodule

// ===== rtl/core/value_stack_pick_roll.sv =====
// Top level of the tagged-word data stack with pick and roll.
//
//  channel  handshake            payload
//  input    in_valid / in_ready  cmd, word_tag, word_bits, depth_index
//  result   res_valid/res_ready  out_tag, out_bits, out_valid, status, fill_level
//
// One word per cycle: the stack cells update at the accepting edge and the
// result lands in the output register, so a word enters every cycle unless
// a result is waiting with res_ready low.
// Reset clears the fill count and the result valid flag; cell contents and
// the result payload stay undefined until written. A stalled result holds;
// in_ready drops meanwhile.
module value_stack_pick_roll #(
	parameter int STACK_DEPTH = vspr_pkg::DEF_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [1:0]  word_tag,
	input  logic [63:0] word_bits,
	input  logic [5:0]  depth_index,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  out_tag,
	output logic [63:0] out_bits,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic [6:0]  fill_level
);
	import vspr_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

	logic             in_fire;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             res_valid_q;
	word_t            res_word_q;
	logic             res_hit_q;
	status_t          res_status_q;
	logic [6:0]       res_fill_q;

	stk_op_t     op_d;
	status_t     status_d;
	logic        hit_d;
	word_t       word_d;
	logic        out_of_range;
	chain_ctrl_t ctrl;
	word_t       push_word;
	word_t       top_word;
	word_t       sel_word;

	assign in_ready = !res_valid_q || res_ready;
	assign in_fire  = in_valid && in_ready;

	assign out_of_range   = CMP_W'(depth_index) >= CMP_W'(count_q);
	assign push_word.tag  = word_tag;
	assign push_word.bits = word_bits;

	always_comb begin
		op_d     = OP_HOLD;
		status_d = ST_OK;
		hit_d    = 1'b0;
		word_d   = '0;
		count_d  = count_q;
		unique case (cmd_t'(cmd))
			CMD_PUSH: begin
				if (count_q == CNT_W'(STACK_DEPTH)) begin
					status_d = ST_OVER;
				end else begin
					op_d    = OP_PUSH;
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP: begin
				if (count_q == '0) begin
					status_d = ST_UNDER;
				end else begin
					op_d    = OP_POP;
					count_d = count_q - 1'b1;
					hit_d   = 1'b1;
					word_d  = top_word;
				end
			end
			CMD_PICK: begin
				if (out_of_range) begin
					status_d = ST_RANGE;
				end else begin
					hit_d  = 1'b1;
					word_d = sel_word;
				end
			end
			CMD_ROLL: begin
				if (out_of_range) begin
					status_d = ST_RANGE;
				end else begin
					op_d = OP_ROLL;
				end
			end
		endcase
	end

	// leave the cells alone unless a word is taken
	assign ctrl.op  = in_fire ? op_d : OP_HOLD;
	assign ctrl.idx = depth_index;

	vspr_chain #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.push_word (push_word),
		.top_word  (top_word),
		.sel_word  (sel_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q <= count_d;
			end
			if (in_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_word_q   <= word_d;
			res_hit_q    <= hit_d;
			res_status_q <= status_d;
			res_fill_q   <= 7'(count_d);
		end
	end

	assign res_valid  = res_valid_q;
	assign out_tag    = res_word_q.tag;
	assign out_bits   = res_word_q.bits;
	assign out_valid  = res_hit_q;
	assign status     = res_status_q;
	assign fill_level = res_fill_q;

endmodule

// ===== rtl/core/vspr_check.sv =====
// Port-level checker for the data stack, bound to the top level.
module vspr_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  cmd,
	input logic [1:0]  word_tag,
	input logic [63:0] word_bits,
	input logic [5:0]  depth_index,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  out_tag,
	input logic [63:0] out_bits,
	input logic        out_valid,
	input logic [1:0]  status,
	input logic [6:0]  fill_level
);
	import vspr_pkg::*;

	// hold a waiting input word
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(word_tag)
			&& $stable(word_bits) && $stable(depth_index))
		else $error("waiting input word changed");

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_bits) && $stable(out_tag)
			&& $stable(status) && $stable(fill_level) && $stable(out_valid))
		else $error("stalled result changed");

	a_zero_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_tag == '0 && out_bits == '0)
		else $error("word fields not cleared without a word");

	a_err_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> !out_valid)
		else $error("word returned with an error status");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_UNDER |-> fill_level == '0)
		else $error("underflow reported on a non-empty stack");

endmodule

bind value_stack_pick_roll vspr_check u_vspr_check (.*);

// ===== tb/tb_value_stack_pick_roll.sv =====
// Self-checking testbench for the tagged-word data stack with pick and roll.
`timescale 1ns / 100ps

module tb_value_stack_pick_roll;
	import vspr_pkg::*;

	localparam int DEPTH       = DEF_STACK_DEPTH;
	localparam int RANDOM_WORDS = 1800;
	localparam int DRAIN_LIMIT = 50000;

	typedef struct {
		logic [1:0]  tag;
		logic [63:0] bits;
		logic        valid;
		status_t     st;
		logic [6:0]  level;
	} stack_result_t;

	// Mirror of the stack contents plus the queue of results still owed
	class stack_mirror;
		logic [1:0]    tag_cells [DEPTH];
		logic [63:0]   bit_cells [DEPTH];
		int unsigned   used;
		stack_result_t owed [$];
		int            mismatches;

		function new();
			used = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void note_word(cmd_t c, logic [1:0] t, logic [63:0] b, logic [5:0] d);
			stack_result_t r;
			int unsigned pos;
			logic [1:0] keep_tag;
			logic [63:0] keep_bits;
			r.tag = '0;
			r.bits = '0;
			r.valid = 1'b0;
			r.st = ST_OK;
			case (c)
			CMD_PUSH: begin
				if (used >= DEPTH) begin
					r.st = ST_OVER;
				end else begin
					tag_cells[used] = t;
					bit_cells[used] = b;
					used++;
				end
			end
			CMD_POP: begin
				if (used == 0) begin
					r.st = ST_UNDER;
				end else begin
					used--;
					r.tag = tag_cells[used];
					r.bits = bit_cells[used];
					r.valid = 1'b1;
				end
			end
			default: begin
				if (d >= used) begin
					r.st = ST_RANGE;
				end else begin
					pos = used - 1 - d;
					if (c == CMD_PICK) begin
						r.tag = tag_cells[pos];
						r.bits = bit_cells[pos];
						r.valid = 1'b1;
					end else begin
						// lift the chosen cell to the top, shift the rest down
						keep_tag = tag_cells[pos];
						keep_bits = bit_cells[pos];
						for (int unsigned i = pos; i + 1 < used; i++) begin
							tag_cells[i] = tag_cells[i + 1];
							bit_cells[i] = bit_cells[i + 1];
						end
						tag_cells[used - 1] = keep_tag;
						bit_cells[used - 1] = keep_bits;
					end
				end
			end
			endcase
			r.level = 7'(used);
			owed.push_back(r);
		endfunction

		function void check_word(logic [1:0] t, logic [63:0] b, logic v, logic [1:0] s,
				logic [6:0] l);
			stack_result_t e;
			if (owed.size() == 0) begin
				$display("%0t: result word with nothing owed (tag %0d bits %h status %0d)",
					$time, t, b, s);
				mismatches++;
				return;
			end
			e = owed.pop_front();
			if (t !== e.tag) begin
				$display("%0t: out_tag expected %0d actual %0d", $time, e.tag, t);
				mismatches++;
			end
			if (b !== e.bits) begin
				$display("%0t: out_bits expected %h actual %h", $time, e.bits, b);
				mismatches++;
			end
			if (v !== e.valid) begin
				$display("%0t: out_valid expected %0d actual %0d", $time, e.valid, v);
				mismatches++;
			end
			if (s !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, s);
				mismatches++;
			end
			if (l !== e.level) begin
				$display("%0t: fill_level expected %0d actual %0d", $time, e.level, l);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_PUSH;
	logic [1:0]  word_tag = '0;
	logic [63:0] word_bits = '0;
	logic [5:0]  depth_index = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  out_tag;
	logic [63:0] out_bits;
	logic        out_valid;
	logic [1:0]  status;
	logic [6:0]  fill_level;

	stack_mirror mirror = new();

	int       gen_level = 0;
	int       words_sent = 0;
	int       burst_left = 0;
	bit       valid_up = 1'b0;
	int       stall_left = 0;
	int       stall_mode = 0;

	value_stack_pick_roll #(.STACK_DEPTH(DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.word_tag    (word_tag),
		.word_bits   (word_bits),
		.depth_index (depth_index),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_tag     (out_tag),
		.out_bits    (out_bits),
		.out_valid   (out_valid),
		.status      (status),
		.fill_level  (fill_level)
	);

	always #2 clk = ~clk;

	// Receiver: switch between always ready, coin toss, heavy stall and a periodic pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
		0: res_ready <= 1'b1;
		1: res_ready <= 1'($urandom_range(0, 1));
		2: res_ready <= ($urandom_range(0, 9) == 0);
		default: res_ready <= stall_left[2];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready)
				mirror.check_word(out_tag, out_bits, out_valid, status, fill_level);
			if (in_valid && in_ready)
				mirror.note_word(cmd_t'(cmd), word_tag, word_bits, depth_index);
		end
	end

	// Present one word and hold it until taken; then maybe drop valid for a gap
	task automatic send_word(cmd_t c, logic [1:0] t, logic [63:0] b, logic [5:0] d);
		in_valid <= 1'b1;
		valid_up = 1'b1;
		cmd <= c;
		word_tag <= t;
		word_bits <= b;
		depth_index <= d;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		if (c == CMD_PUSH && gen_level < DEPTH)
			gen_level++;
		else if (c == CMD_POP && gen_level > 0)
			gen_level--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 60);
		end else begin
			burst_left--;
		end
	endtask

	task automatic hold_until_drained();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
		do @(posedge clk); while (mirror.pending() != 0);
	endtask

	function automatic logic [5:0] pick_index();
		int r = $urandom_range(0, 9);
		if (gen_level == 0 || r == 0)
			return 6'($urandom);
		// first index past the stack, or the deepest one still on it
		if (r == 1)
			return (gen_level >= DEPTH) ? 6'(DEPTH - 1) : 6'(gen_level);
		if (r == 2)
			return 6'(gen_level - 1);
		return 6'($urandom_range(0, gen_level - 1));
	endfunction

	task automatic issue_random(int push_pct);
		cmd_t c;
		if ($urandom_range(0, 99) < push_pct) begin
			c = CMD_PUSH;
		end else begin
			case ($urandom_range(0, 2))
			0: c = CMD_POP;
			1: c = CMD_PICK;
			default: c = CMD_ROLL;
			endcase
		end
		send_word(c, 2'($urandom), {$urandom, $urandom}, pick_index());
	endtask

	task automatic fill_to_top();
		while (gen_level < DEPTH)
			send_word(CMD_PUSH, 2'($urandom), {$urandom, $urandom}, 6'($urandom));
		repeat (3) send_word(CMD_PUSH, 2'($urandom), {$urandom, $urandom}, 6'($urandom));
		send_word(CMD_PICK, 2'($urandom), {$urandom, $urandom}, 6'(DEPTH - 1));
		send_word(CMD_ROLL, 2'($urandom), {$urandom, $urandom}, 6'(DEPTH - 1));
		send_word(CMD_PICK, 2'($urandom), {$urandom, $urandom}, 6'd0);
		repeat (4) send_word(CMD_ROLL, 2'($urandom), {$urandom, $urandom}, 6'($urandom));
	endtask

	task automatic drain_to_floor();
		while (gen_level > 0)
			send_word(CMD_POP, 2'($urandom), {$urandom, $urandom}, 6'($urandom));
		repeat (2) send_word(CMD_POP, 2'($urandom), {$urandom, $urandom}, 6'($urandom));
	endtask

	initial begin
		int push_pct;
		int waited;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge cases on an empty stack, then a small four-deep stack
		send_word(CMD_POP,  2'd0, 64'd0, 6'd0);
		send_word(CMD_PICK, 2'd0, 64'd0, 6'd0);
		send_word(CMD_ROLL, 2'd3, '1, 6'd63);
		send_word(CMD_PUSH, 2'd0, 64'd0, 6'd0);
		send_word(CMD_PUSH, 2'd3, '1, 6'd63);
		send_word(CMD_PUSH, 2'd1, 64'hAAAA_AAAA_AAAA_AAAA, 6'd21);
		send_word(CMD_PUSH, 2'd2, 64'h5555_5555_5555_5555, 6'd42);
		send_word(CMD_PICK, 2'd0, 64'd0, 6'd0);
		send_word(CMD_PICK, 2'd0, 64'd0, 6'd3);
		send_word(CMD_PICK, 2'd0, 64'd0, 6'd4);
		send_word(CMD_ROLL, 2'd0, 64'd0, 6'd0);
		send_word(CMD_ROLL, 2'd0, 64'd0, 6'd3);
		send_word(CMD_ROLL, 2'd0, 64'd0, 6'd1);
		send_word(CMD_PICK, 2'd0, 64'd0, 6'd63);
		send_word(CMD_ROLL, 2'd0, 64'd0, 6'd4);
		send_word(CMD_PICK, 2'd0, 64'd0, 6'd1);
		send_word(CMD_PICK, 2'd0, 64'd0, 6'd2);
		repeat (4) send_word(CMD_POP, 2'd0, 64'd0, 6'd0);
		send_word(CMD_POP, 2'd0, 64'd0, 6'd0);

		fill_to_top();
		hold_until_drained();
		drain_to_floor();

		while (words_sent < RANDOM_WORDS + 25) begin
			case ($urandom_range(0, 4))
			0: push_pct = 70;
			1: push_pct = 15;
			2, 3: push_pct = 40;
			default: push_pct = -1;
			endcase
			if (push_pct < 0)
				fill_to_top();
			else
				repeat ($urandom_range(40, 150)) issue_random(push_pct);
			if ($urandom_range(0, 4) == 0)
				hold_until_drained();
		end

		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
		waited = 0;
		while (mirror.pending() != 0) begin
			@(posedge clk);
			waited++;
			if (waited > DRAIN_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
		repeat (10) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5ms;
		$display("%0t: run did not finish in time", $time);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/vspr_pkg.sv
rtl/core/vspr_cell.sv
rtl/core/vspr_chain.sv
rtl/core/value_stack_pick_roll.sv
rtl/core/vspr_check.sv
tb/tb_value_stack_pick_roll.sv
